### sv/etd_pkg.sv
// shared types and constants for the enigma tilemap decompressor
`default_nettype none

package etd_pkg;

   // results one byte may produce before the rest waits for the next byte
   localparam int MAX_RESULTS = 32;
   localparam int COUNT_W     = $clog2(MAX_RESULTS + 1);

   // result status codes
   localparam logic [1:0] STATUS_WORD      = 2'd0;
   localparam logic [1:0] STATUS_END       = 2'd1;
   localparam logic [1:0] STATUS_BAD_WIDTH = 2'd2;

   // register map, indexed by paddr word bit
   localparam logic REG_BASE_TILE = 1'b0;

   // input transaction
   typedef struct packed {
      logic [7:0] stream_byte;
      logic       start_stream;
   } req_type;

   // result transaction
   typedef struct packed {
      logic [15:0] tile_word;
      logic [1:0]  status;
      logic        last_of_run;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic load;   // take the accepted byte
      logic step;   // run one parse step
      logic flush;  // move the held result out, marked last
   } etd_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic stop;        // parse step cannot proceed, byte finished
      logic emit;        // parse step produces a result
      logic end_mark;    // parse step hits the end marker
      logic pend_valid;  // a result is held back
      logic slot_free;   // output register can take a result this cycle
   } etd_stat_type;

endpackage

`default_nettype wire

### sv/enigma_tilemap_decompressor.sv
// top level of the enigma tilemap decompressor
//
// usage
//   req channel: one compressed byte per transaction, start_stream set on the
//   first header byte of each stream; a start abandons any stream in progress.
//   rsp channel: decoded tile words, an end marker result (status 1) or a bad
//   width result (status 2); last_of_run marks the last result of a byte.
//   csr port: base_tile at byte address 0, written while the block is idle.
// sequence
//   a byte is loaded, then runs its parse steps, then the controller finds
//   the byte used up and releases its last result; a byte that ends on the
//   end marker releases it straight after its steps.
//   steps: one per packet code, five flag positions per inline value whether
//   or not the mask bit is set, one per inline value field, which also emits
//   a list word, and one per copy or run word; a copy packet of n words costs
//   n + 1 steps, an inline run n + 7, all in the single parse step unit. a
//   result waits in a holding register until the next result or the end of
//   the byte moves it to the output register, where it shows.
// reset and stalls
//   reset clears the parser to waiting for a start and empties the output.
//   while rsp_stall is high the output holds and parsing pauses once a further
//   result is ready behind the held one; req_stall stays high until the last
//   result of the byte has reached the output register.
`default_nettype none

module enigma_tilemap_decompressor
   import etd_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   // input channel
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire req_type      req_data,
   // result channel
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output rsp_type           rsp_data,
   // configuration port
   input  wire logic         csr_psel,
   input  wire logic         csr_penable,
   input  wire logic         csr_pwrite,
   input  wire logic [2:0]   csr_paddr,
   input  wire logic [31:0]  csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);

   logic [15:0]   base_tile_ff, base_tile_in;
   logic          csr_write;
   etd_cmd_type   cmd;
   etd_stat_type  stat;

   // configuration register
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (csr_paddr[2] == REG_BASE_TILE);
   assign base_tile_in = csr_write ? csr_pwdata[15:0] : base_tile_ff;
   assign csr_prdata   = (csr_paddr[2] == REG_BASE_TILE) ? {16'h0000, base_tile_ff} : 32'h0;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_tile_ff <= 16'd0;
      end else begin
         base_tile_ff <= base_tile_in;
      end
   end

   etd_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   etd_datapath u_dp (
      .clock     (clock),
      .reset     (reset),
      .base_tile (base_tile_ff),
      .req_data  (req_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

### sv/etd_datapath.sv
// parse state, bit buffer, word arithmetic and output registers
`default_nettype none

module etd_datapath
   import etd_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic [15:0]  base_tile,
   input  wire req_type      req_data,
   input  wire etd_cmd_type  cmd,
   output etd_stat_type      stat,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output rsp_type           rsp_data
);

   // parse phases
   localparam logic [3:0] PH_IDLE   = 4'd0;
   localparam logic [3:0] PH_HEADER = 4'd1;
   localparam logic [3:0] PH_PACKET = 4'd2;
   localparam logic [3:0] PH_FLAG   = 4'd3;
   localparam logic [3:0] PH_VALUE  = 4'd8;
   localparam logic [3:0] PH_EMIT   = 4'd9;
   localparam logic [3:0] PH_DONE   = 4'd10;

   // packet types
   localparam logic [2:0] PT_INCR = 3'd0;
   localparam logic [2:0] PT_COMMON = 3'd1;
   localparam logic [2:0] PT_UP = 3'd5;
   localparam logic [2:0] PT_DOWN = 3'd6;
   localparam logic [2:0] PT_SEPARATE = 3'd7;

   // parse state
   logic [3:0]  phase_ff, phase_in;
   logic [2:0]  hidx_ff, hidx_in;
   logic [23:0] buf_ff, buf_in;
   logic [4:0]  held_ff, held_in;
   logic [4:0]  width_ff, width_in;
   logic [4:0]  mask_ff, mask_in;
   logic [15:0] incr_ff, incr_in;
   logic [15:0] common_ff, common_in;
   logic [2:0]  ptype_ff, ptype_in;
   logic [4:0]  rcnt_ff, rcnt_in;
   logic [15:0] ival_ff, ival_in;

   // held result and output register
   logic        pend_valid_ff, pend_valid_in;
   logic [15:0] pend_word_ff, pend_word_in;
   logic [1:0]  pend_status_ff, pend_status_in;
   logic        out_valid_ff, out_valid_in;
   rsp_type     out_ff, out_in;

   // load path values
   logic [3:0]  ld_phase;
   logic [2:0]  ld_hidx;
   logic [23:0] ld_buf;
   logic [4:0]  ld_held;
   logic [4:0]  ld_width;
   logic [4:0]  ld_mask;
   logic [15:0] ld_incr;
   logic [15:0] ld_common;
   logic        ld_bad;

   // parse step values
   logic [3:0]  it_phase;
   logic [23:0] it_buf;
   logic [4:0]  it_held;
   logic [4:0]  it_width;
   logic [15:0] it_incr;
   logic [2:0]  it_ptype;
   logic [4:0]  it_rcnt;
   logic [15:0] it_ival;
   logic        it_stop;
   logic        it_emit;
   logic        it_end;
   logic [15:0] it_word;
   logic [1:0]  it_status;

   // bit extraction
   logic [4:0]  width_eff;
   logic [4:0]  take_n;
   logic        avail;
   logic        top_bit;
   logic [23:0] top_shift;
   logic [23:0] shifted;
   logic [15:0] taken;
   logic [4:0]  held_after;
   logic [23:0] buf_after;
   logic [2:0]  flag_k;
   logic        in_flag;
   logic        push;
   logic        slot_free;

   assign width_eff = (width_ff == 5'd0 || width_ff > 5'd16) ? 5'd16 : width_ff;
   assign in_flag   = (phase_ff >= PH_FLAG) && (phase_ff < PH_VALUE);
   assign flag_k    = 3'(4'd7 - phase_ff);
   assign top_shift = buf_ff >> (held_ff - 5'd1);
   assign top_bit   = top_shift[0];

   // bits to take in this step
   always_comb begin
      take_n = 5'd1;
      if (phase_ff == PH_PACKET) begin
         take_n = top_bit ? 5'd7 : 5'd6;
      end else if (phase_ff == PH_VALUE) begin
         take_n = width_eff;
      end
   end

   assign avail      = held_ff >= take_n;
   assign shifted    = buf_ff >> (held_ff - take_n);
   assign taken      = shifted[15:0] & 16'((17'd1 << take_n) - 17'd1);
   assign held_after = held_ff - take_n;
   assign buf_after  = buf_ff & 24'((25'd1 << held_after) - 25'd1);

   // one parse step
   always_comb begin
      it_phase  = phase_ff;
      it_buf    = buf_ff;
      it_held   = held_ff;
      it_width  = width_ff;
      it_incr   = incr_ff;
      it_ptype  = ptype_ff;
      it_rcnt   = rcnt_ff;
      it_ival   = ival_ff;
      it_stop   = 1'b0;
      it_emit   = 1'b0;
      it_end    = 1'b0;
      it_word   = 16'd0;
      it_status = STATUS_WORD;
      if (phase_ff == PH_PACKET) begin
         if (held_ff == 5'd0 || !avail) begin
            it_stop = 1'b1;
         end else if (!top_bit) begin
            // incrementing or common copy
            it_buf   = buf_after;
            it_held  = held_after;
            it_ptype = {2'b00, taken[4]};
            it_rcnt  = {1'b0, taken[3:0]} + 5'd1;
            it_phase = PH_EMIT;
         end else if (taken[6:4] == PT_SEPARATE && taken[3:0] == 4'hf) begin
            // end marker, trailing bits dropped
            it_ptype  = taken[6:4];
            it_emit   = 1'b1;
            it_end    = 1'b1;
            it_status = STATUS_END;
            it_phase  = PH_DONE;
            it_buf    = 24'd0;
            it_held   = 5'd0;
         end else begin
            it_buf   = buf_after;
            it_held  = held_after;
            it_ptype = taken[6:4];
            it_rcnt  = {1'b0, taken[3:0]} + 5'd1;
            it_ival  = base_tile;
            it_phase = PH_FLAG;
         end
      end else if (in_flag) begin
         // one optional flag bit
         if (mask_ff[flag_k]) begin
            if (!avail) begin
               it_stop = 1'b1;
            end else begin
               it_buf  = buf_after;
               it_held = held_after;
               if (taken[0]) begin
                  case (flag_k)
                     3'd4:    it_ival = ival_ff | 16'h8000;
                     3'd3:    it_ival = ival_ff + 16'h4000;
                     3'd2:    it_ival = ival_ff + 16'h2000;
                     3'd1:    it_ival = ival_ff | 16'h1000;
                     default: it_ival = ival_ff | 16'h0800;
                  endcase
               end
            end
         end
         if (!it_stop) begin
            it_phase = phase_ff + 4'd1;
         end
      end else if (phase_ff == PH_VALUE) begin
         // inline value field
         it_width = width_eff;
         if (!avail) begin
            it_stop = 1'b1;
         end else begin
            it_buf  = buf_after;
            it_held = held_after;
            it_ival = ival_ff + taken;
            if (ptype_ff == PT_SEPARATE) begin
               it_emit = 1'b1;
               it_word = it_ival;
               if (rcnt_ff != 5'd0) begin
                  it_rcnt = rcnt_ff - 5'd1;
               end
               if (it_rcnt == 5'd0) begin
                  it_phase = PH_PACKET;
               end else begin
                  it_ival  = base_tile;
                  it_phase = PH_FLAG;
               end
            end else begin
               it_phase = PH_EMIT;
            end
         end
      end else if (phase_ff == PH_EMIT) begin
         // one word of a run
         if (rcnt_ff == 5'd0) begin
            it_phase = PH_PACKET;
         end else begin
            it_emit = 1'b1;
            case (ptype_ff)
               PT_INCR: begin
                  it_word = incr_ff;
                  it_incr = incr_ff + 16'd1;
               end
               PT_COMMON: it_word = common_ff;
               PT_UP: begin
                  it_word = ival_ff;
                  it_ival = ival_ff + 16'd1;
               end
               PT_DOWN: begin
                  it_word = ival_ff;
                  it_ival = ival_ff - 16'd1;
               end
               default: it_word = ival_ff;
            endcase
            it_rcnt = rcnt_ff - 5'd1;
            if (it_rcnt == 5'd0) begin
               it_phase = PH_PACKET;
            end
         end
      end else begin
         it_stop = 1'b1;
      end
   end

   // accepted byte: restart, header field or bit buffer append
   always_comb begin
      ld_phase  = req_data.start_stream ? PH_HEADER : phase_ff;
      ld_hidx   = req_data.start_stream ? 3'd0 : hidx_ff;
      ld_buf    = req_data.start_stream ? 24'd0 : buf_ff;
      ld_held   = req_data.start_stream ? 5'd0 : held_ff;
      ld_width  = width_ff;
      ld_mask   = mask_ff;
      ld_incr   = incr_ff;
      ld_common = common_ff;
      ld_bad    = 1'b0;
      if (ld_phase == PH_HEADER) begin
         case (ld_hidx)
            3'd0: begin
               if (req_data.stream_byte == 8'd0 || req_data.stream_byte > 8'd16) begin
                  ld_bad   = 1'b1;
                  ld_phase = PH_IDLE;
               end else begin
                  ld_width = req_data.stream_byte[4:0];
               end
            end
            3'd1: ld_mask = req_data.stream_byte[4:0];
            3'd2: ld_incr = {req_data.stream_byte, 8'h00};
            3'd3: ld_incr = (incr_ff | {8'h00, req_data.stream_byte}) + base_tile;
            3'd4: ld_common = {req_data.stream_byte, 8'h00};
            default: begin
               ld_common = (common_ff | {8'h00, req_data.stream_byte}) + base_tile;
               ld_phase  = PH_PACKET;
            end
         endcase
         ld_hidx = ld_hidx + 3'd1;
      end else if (ld_phase >= PH_PACKET && ld_phase <= PH_EMIT && ld_held <= 5'd16) begin
         ld_buf  = {ld_buf[15:0], req_data.stream_byte};
         ld_held = ld_held + 5'd8;
      end
   end

   // next state selection
   always_comb begin
      phase_in  = phase_ff;
      hidx_in   = hidx_ff;
      buf_in    = buf_ff;
      held_in   = held_ff;
      width_in  = width_ff;
      mask_in   = mask_ff;
      incr_in   = incr_ff;
      common_in = common_ff;
      ptype_in  = ptype_ff;
      rcnt_in   = rcnt_ff;
      ival_in   = ival_ff;
      if (cmd.load) begin
         phase_in  = ld_phase;
         hidx_in   = ld_hidx;
         buf_in    = ld_buf;
         held_in   = ld_held;
         width_in  = ld_width;
         mask_in   = ld_mask;
         incr_in   = ld_incr;
         common_in = ld_common;
         if (req_data.start_stream) begin
            ptype_in = 3'd0;
            rcnt_in  = 5'd0;
            ival_in  = 16'd0;
         end
      end else if (cmd.step) begin
         phase_in = it_phase;
         buf_in   = it_buf;
         held_in  = it_held;
         width_in = it_width;
         incr_in  = it_incr;
         ptype_in = it_ptype;
         rcnt_in  = it_rcnt;
         ival_in  = it_ival;
      end
   end

   // held result and output register
   assign slot_free = !out_valid_ff || !rsp_stall;
   assign push      = pend_valid_ff && ((cmd.step && it_emit) || cmd.flush);

   always_comb begin
      pend_valid_in  = pend_valid_ff;
      pend_word_in   = pend_word_ff;
      pend_status_in = pend_status_ff;
      out_valid_in   = out_valid_ff && rsp_stall;
      out_in         = out_ff;
      if (push) begin
         out_valid_in       = 1'b1;
         out_in.tile_word   = pend_word_ff;
         out_in.status      = pend_status_ff;
         out_in.last_of_run = cmd.flush;
      end
      if (cmd.load && ld_bad) begin
         pend_valid_in  = 1'b1;
         pend_word_in   = 16'd0;
         pend_status_in = STATUS_BAD_WIDTH;
      end else if (cmd.step && it_emit) begin
         pend_valid_in  = 1'b1;
         pend_word_in   = it_word;
         pend_status_in = it_status;
      end else if (cmd.flush) begin
         pend_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         hidx_ff       <= 3'd0;
         buf_ff        <= 24'd0;
         held_ff       <= 5'd0;
         width_ff      <= 5'd0;
         mask_ff       <= 5'd0;
         incr_ff       <= 16'd0;
         common_ff     <= 16'd0;
         ptype_ff      <= 3'd0;
         rcnt_ff       <= 5'd0;
         ival_ff       <= 16'd0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         hidx_ff       <= hidx_in;
         buf_ff        <= buf_in;
         held_ff       <= held_in;
         width_ff      <= width_in;
         mask_ff       <= mask_in;
         incr_ff       <= incr_in;
         common_ff     <= common_in;
         ptype_ff      <= ptype_in;
         rcnt_ff       <= rcnt_in;
         ival_ff       <= ival_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      pend_word_ff   <= pend_word_in;
      pend_status_ff <= pend_status_in;
      out_ff         <= out_in;
   end

   assign stat.stop       = it_stop;
   assign stat.emit       = it_emit;
   assign stat.end_mark   = it_end;
   assign stat.pend_valid = pend_valid_ff;
   assign stat.slot_free  = slot_free;
   assign rsp_valid       = out_valid_ff;
   assign rsp_data        = out_ff;

endmodule

`default_nettype wire

### sv/etd_controller.sv
// sequencer: byte load, parse steps and result flush
`default_nettype none

module etd_controller
   import etd_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_stall,
   input  wire etd_stat_type  stat,
   output etd_cmd_type        cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_FLUSH
   } state_type;

   state_type            state_ff, state_in;
   logic [COUNT_W-1:0]   result_count_ff, result_count_in;

   // commands and next state
   always_comb begin
      state_in        = state_ff;
      result_count_in = result_count_ff;
      cmd             = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load        = 1'b1;
               result_count_in = '0;
               state_in        = ST_RUN;
            end
         end
         ST_RUN: begin
            if (result_count_ff == COUNT_W'(MAX_RESULTS) || stat.stop) begin
               state_in = ST_FLUSH;
            end else if (!(stat.emit && stat.pend_valid && !stat.slot_free)) begin
               cmd.step = 1'b1;
               if (stat.emit) begin
                  result_count_in = result_count_ff + COUNT_W'(1);
               end
               if (stat.end_mark) begin
                  state_in = ST_FLUSH;
               end
            end
         end
         ST_FLUSH: begin
            if (!stat.pend_valid) begin
               state_in = ST_IDLE;
            end else if (stat.slot_free) begin
               cmd.flush = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         result_count_ff <= '0;
      end else begin
         state_ff        <= state_in;
         result_count_ff <= result_count_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

endmodule

`default_nettype wire

### sv/etd_checker.sv
// port-level checks on the result channel, bound to the top level
`default_nettype none

module etd_checker
   import etd_pkg::*;
(
   input wire logic     clock,
   input wire logic     reset,
   input wire logic     rsp_valid,
   input wire logic     rsp_stall,
   input wire rsp_type  rsp_data
);

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // reset empties the output
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result present after reset");

   // end and error results carry no word
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != STATUS_WORD |-> rsp_data.tile_word == 16'd0)
      else $error("non-word result with a tile word");

   // end and error results close the byte
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != STATUS_WORD |-> rsp_data.last_of_run)
      else $error("non-word result not marked last");

   // only defined status codes
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.status == STATUS_WORD || rsp_data.status == STATUS_END
                    || rsp_data.status == STATUS_BAD_WIDTH)
      else $error("undefined status code");

endmodule

bind enigma_tilemap_decompressor etd_checker u_etd_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire

### tb/tb_top.sv
// self-checking testbench for the enigma tilemap decompressor
`timescale 1ns / 100ps

module tb_top;
   import etd_pkg::*;

   // packet codes of the enigma bitstream
   localparam logic [2:0] PKT_INC    = 3'd0;
   localparam logic [2:0] PKT_COMMON = 3'd1;
   localparam logic [2:0] PKT_REPEAT = 3'd4;
   localparam logic [2:0] PKT_UP     = 3'd5;
   localparam logic [2:0] PKT_DOWN   = 3'd6;
   localparam logic [2:0] PKT_LIST   = 3'd7;
   localparam logic [6:0] END_MARK   = 7'h7F;

   localparam logic [2:0] BASE_TILE_ADDR = {REG_BASE_TILE, 2'b00};
   localparam int DRAIN_CYCLES = 64;
   localparam int PHASE_ITEMS  = 14;

   // decoder phases of the predictor
   typedef enum logic [3:0] {
      DEC_WAIT_START, DEC_HEADER, DEC_PACKET, DEC_FLAGS, DEC_VALUE, DEC_EMIT, DEC_DONE
   } dec_phase_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   enigma_tilemap_decompressor dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #4 clock = ~clock;

   // stimulus and expected results
   req_type     byte_q [$];
   rsp_type     tile_q [$];
   bit          stream_bits [$];
   int unsigned items_queued = 0;
   int unsigned issued_cnt = 0;
   int unsigned accepted_cnt = 0;
   int unsigned checked_cnt = 0;
   int unsigned streams_built = 0;
   int unsigned base_writes = 0;
   int unsigned errors = 0;

   // predictor state
   logic [15:0]   tile_base = '0;
   dec_phase_type dec_phase = DEC_WAIT_START;
   logic [2:0]    hdr_idx = '0;
   logic [23:0]   bitbuf = '0;
   logic [4:0]    held = '0;
   logic [4:0]    value_width = '0;
   logic [4:0]    fmask = '0;
   logic [15:0]   inc_word = '0;
   logic [15:0]   com_word = '0;
   logic [2:0]    pkt = '0;
   logic [4:0]    words_left = '0;
   logic [15:0]   cur_value = '0;
   logic [2:0]    flag_k = '0;
   int            run_len = 0;

   // pull nb bits, msb first, from the bit buffer
   function automatic logic [15:0] take_bits(input int unsigned nb);
      logic [31:0] wide;
      wide = {8'h00, bitbuf} >> (held - nb);
      held = held - 5'(nb);
      bitbuf = 24'({8'h00, bitbuf} & ((32'd1 << held) - 32'd1));
      return 16'(wide & ((32'd1 << nb) - 32'd1));
   endfunction

   function automatic void expect_word(input logic [15:0] word, input logic [1:0] status);
      rsp_type r;
      r.tile_word   = word;
      r.status      = status;
      r.last_of_run = 1'b0;
      tile_q.push_back(r);
      run_len++;
   endfunction

   // work out the results of one accepted byte
   task automatic decode_byte(input req_type item);
      logic [15:0] v;
      logic [3:0]  cnt;
      rsp_type     r;
      bit          go;
      run_len = 0;
      go = 1'b1;
      if (item.start_stream) begin
         dec_phase  = DEC_HEADER;
         hdr_idx    = '0;
         bitbuf     = '0;
         held       = '0;
         pkt        = '0;
         words_left = '0;
         cur_value  = '0;
      end
      if (dec_phase == DEC_HEADER) begin
         case (hdr_idx)
            3'd0: begin
               if (item.stream_byte < 8'd1 || item.stream_byte > 8'd16) begin
                  expect_word(16'h0000, STATUS_BAD_WIDTH);
                  dec_phase = DEC_WAIT_START;
               end else begin
                  value_width = item.stream_byte[4:0];
               end
            end
            3'd1: fmask = item.stream_byte[4:0];
            3'd2: inc_word = {item.stream_byte, 8'h00};
            3'd3: inc_word = {inc_word[15:8], item.stream_byte} + tile_base;
            3'd4: com_word = {item.stream_byte, 8'h00};
            default: begin
               com_word  = {com_word[15:8], item.stream_byte} + tile_base;
               dec_phase = DEC_PACKET;
            end
         endcase
         hdr_idx = hdr_idx + 3'd1;
      end else if (dec_phase != DEC_WAIT_START && dec_phase != DEC_DONE) begin
         // bytes arriving with more than two bytes held are dropped
         if (held <= 5'd16) begin
            bitbuf = {bitbuf[15:0], item.stream_byte};
            held   = held + 5'd8;
         end
         while (go && run_len < MAX_RESULTS) begin
            case (dec_phase)
               DEC_PACKET: begin
                  if (held == 5'd0) begin
                     go = 1'b0;
                  end else if (!bitbuf[held - 5'd1]) begin
                     if (held < 5'd6) begin
                        go = 1'b0;
                     end else begin
                        v          = take_bits(6);
                        pkt        = {2'b00, v[4]};
                        words_left = {1'b0, v[3:0]} + 5'd1;
                        dec_phase  = DEC_EMIT;
                     end
                  end else if (held < 5'd7) begin
                     go = 1'b0;
                  end else begin
                     v   = take_bits(7);
                     pkt = v[6:4];
                     cnt = v[3:0];
                     if (pkt == PKT_LIST && cnt == 4'hF) begin
                        expect_word(16'h0000, STATUS_END);
                        dec_phase = DEC_DONE;
                        bitbuf    = '0;
                        held      = '0;
                        go        = 1'b0;
                     end else begin
                        words_left = {1'b0, cnt} + 5'd1;
                        cur_value  = tile_base;
                        flag_k     = 3'd4;
                        dec_phase  = DEC_FLAGS;
                     end
                  end
               end
               DEC_FLAGS: begin
                  // one optional bit per set mask bit, priority first
                  if (fmask[flag_k] && held == 5'd0) begin
                     go = 1'b0;
                  end else begin
                     if (fmask[flag_k]) begin
                        v = take_bits(1);
                        if (v[0]) begin
                           case (flag_k)
                              3'd4:    cur_value = cur_value | 16'h8000;
                              3'd3:    cur_value = cur_value + 16'h4000;
                              3'd2:    cur_value = cur_value + 16'h2000;
                              3'd1:    cur_value = cur_value | 16'h1000;
                              default: cur_value = cur_value | 16'h0800;
                           endcase
                        end
                     end
                     if (flag_k == 3'd0) dec_phase = DEC_VALUE;
                     else flag_k = flag_k - 3'd1;
                  end
               end
               DEC_VALUE: begin
                  if (value_width < 5'd1 || value_width > 5'd16) value_width = 5'd16;
                  if (held < value_width) begin
                     go = 1'b0;
                  end else begin
                     v = take_bits(value_width);
                     cur_value = cur_value + v;
                     if (pkt == PKT_LIST) begin
                        expect_word(cur_value, STATUS_WORD);
                        if (words_left > 5'd0) words_left = words_left - 5'd1;
                        if (words_left == 5'd0) begin
                           dec_phase = DEC_PACKET;
                        end else begin
                           cur_value = tile_base;
                           flag_k    = 3'd4;
                           dec_phase = DEC_FLAGS;
                        end
                     end else begin
                        dec_phase = DEC_EMIT;
                     end
                  end
               end
               DEC_EMIT: begin
                  if (words_left == 5'd0) begin
                     dec_phase = DEC_PACKET;
                  end else begin
                     case (pkt)
                        PKT_INC: begin
                           expect_word(inc_word, STATUS_WORD);
                           inc_word = inc_word + 16'd1;
                        end
                        PKT_COMMON: expect_word(com_word, STATUS_WORD);
                        default: begin
                           expect_word(cur_value, STATUS_WORD);
                           if (pkt == PKT_UP) cur_value = cur_value + 16'd1;
                           else if (pkt == PKT_DOWN) cur_value = cur_value - 16'd1;
                        end
                     endcase
                     words_left = words_left - 5'd1;
                     if (words_left == 5'd0) dec_phase = DEC_PACKET;
                  end
               end
               default: go = 1'b0;
            endcase
         end
      end
      // the last result of the byte carries last_of_run
      if (run_len > 0) begin
         r = tile_q.pop_back();
         r.last_of_run = 1'b1;
         tile_q.push_back(r);
      end
   endtask

   // stream building
   function automatic void queue_byte(input logic [7:0] b, input logic start);
      req_type r;
      r.stream_byte  = b;
      r.start_stream = start;
      byte_q.push_back(r);
      items_queued++;
   endfunction

   function automatic void put_bits(input int unsigned val, input int nb);
      int i;
      for (i = nb - 1; i >= 0; i--) stream_bits.push_back(val[i]);
   endfunction

   function automatic void send_header(input logic [7:0] width_byte, input logic [7:0] flags_byte,
                                       input logic [15:0] inc, input logic [15:0] com);
      queue_byte(width_byte, 1'b1);
      queue_byte(flags_byte, 1'b0);
      queue_byte(inc[15:8], 1'b0);
      queue_byte(inc[7:0], 1'b0);
      queue_byte(com[15:8], 1'b0);
      queue_byte(com[7:0], 1'b0);
      streams_built++;
   endfunction

   function automatic void put_inline(input logic [4:0] flags, input int unsigned val,
                                      input int width, input logic [4:0] mask);
      int k;
      for (k = 4; k >= 0; k--) if (mask[k]) put_bits(flags[k], 1);
      put_bits(val, width);
   endfunction

   // packet with random inline content
   function automatic void put_packet(input logic [2:0] kind, input logic [3:0] cnt,
                                      input int width, input logic [4:0] mask);
      int j;
      if (kind == PKT_INC || kind == PKT_COMMON) put_bits(kind, 2);
      else put_bits(kind, 3);
      put_bits(cnt, 4);
      if (kind == PKT_LIST) begin
         for (j = 0; j <= cnt; j++) put_inline(5'($urandom), $urandom, width, mask);
      end else if (kind != PKT_INC && kind != PKT_COMMON) begin
         put_inline(5'($urandom), $urandom, width, mask);
      end
   endfunction

   // bits to bytes, random padding after the last bit
   function automatic void pack_stream();
      logic [7:0] b;
      int i;
      while (stream_bits.size() > 0) begin
         for (i = 7; i >= 0; i--)
            b[i] = (stream_bits.size() > 0) ? stream_bits.pop_front() : 1'($urandom);
         queue_byte(b, 1'b0);
      end
   endfunction

   // one apb transfer, setup then access
   task automatic csr_access(input logic wr, input logic [31:0] wdata, output logic [31:0] rdata);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= BASE_TILE_ADDR;
      csr_pwdata  <= wdata;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      rdata = csr_prdata;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic set_base_tile(input logic [15:0] val);
      logic [31:0] rd;
      csr_access(1'b1, {16'h0000, val}, rd);
      tile_base = val;
      base_writes++;
      csr_access(1'b0, 32'h0, rd);
      if (rd[15:0] !== val) begin
         $error("base_tile readback: expected %h, actual %h", val, rd[15:0]);
         errors++;
      end
   endtask

   // block idle: nothing queued, in flight or owed, then a margin for silent steps
   task automatic wait_drained();
      while (byte_q.size() != 0 || issued_cnt != accepted_cnt || tile_q.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic random_traffic(input int budget);
      int unsigned start_cnt;
      int          npk, i, width, kind_sel;
      logic [7:0]  flags_byte;
      logic [2:0]  kind;
      logic [3:0]  cnt;
      start_cnt = items_queued;
      while (items_queued - start_cnt < budget) begin
         width = $urandom_range(1, 16);
         flags_byte = 8'($urandom);
         case ($urandom_range(0, 9))
            7: begin
               // bad width, trailing bytes ignored
               queue_byte(($urandom_range(0, 1) == 0) ? 8'd0 : 8'($urandom_range(17, 255)), 1'b1);
               npk = $urandom_range(0, 2);
               for (i = 0; i < npk; i++) queue_byte(8'($urandom), 1'b0);
            end
            8: begin
               // valid header over a noise bitstream
               send_header(8'(width), flags_byte, 16'($urandom), 16'($urandom));
               npk = $urandom_range(2, 6);
               for (i = 0; i < npk; i++) queue_byte(8'($urandom), 1'b0);
            end
            9: begin
               // raw noise, occasionally restarting
               npk = $urandom_range(1, 4);
               for (i = 0; i < npk; i++)
                  queue_byte(8'($urandom), ($urandom_range(0, 3) == 0));
            end
            default: begin
               send_header(8'(width), flags_byte, 16'($urandom), 16'($urandom));
               npk = $urandom_range(1, 6);
               for (i = 0; i < npk; i++) begin
                  // pick one of the six packet codes
                  kind_sel = $urandom_range(0, 5);
                  kind = (kind_sel < 2) ? 3'(kind_sel) : 3'(kind_sel + 2);
                  cnt = (kind == PKT_LIST) ? 4'($urandom_range(0, 14)) : 4'($urandom);
                  put_packet(kind, cnt, width, flags_byte[4:0]);
               end
               // most streams end cleanly, the rest are abandoned by the next start
               if ($urandom_range(0, 19) < 17) put_bits(END_MARK, 7);
               pack_stream();
            end
         endcase
      end
   endtask

   // driver: bursts of transactions with random gaps
   int burst_left = 1;
   int gap_left = 0;

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && issued_cnt != accepted_cnt) begin
         // stalled: hold the payload
      end else if (gap_left > 0) begin
         req_valid <= 1'b0;
         gap_left--;
      end else if (byte_q.size() != 0) begin
         req_data  <= byte_q.pop_front();
         req_valid <= 1'b1;
         issued_cnt++;
         if (burst_left > 1) begin
            burst_left--;
         end else begin
            burst_left = $urandom_range(1, 16);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         end
      end else begin
         req_valid <= 1'b0;
      end
   end

   // receiver stall pattern: short stall runs and long free stretches
   int stall_left = 0;
   int free_left = 0;

   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else begin
         rsp_stall <= 1'b0;
         if (free_left > 0) begin
            free_left--;
         end else if ($urandom_range(0, 4) == 0) begin
            free_left = $urandom_range(16, 64);
         end else begin
            stall_left = $urandom_range(1, 6);
            free_left = $urandom_range(0, 4);
         end
      end
   end

   // monitor: predict on accepted bytes, check accepted results
   always @(posedge clock) begin : monitor
      rsp_type want;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            decode_byte(req_data);
            accepted_cnt++;
         end
         if (rsp_valid && !rsp_stall) begin
            if (tile_q.size() == 0) begin
               $error("unexpected result: tile_word %h status %0d last_of_run %0d",
                      rsp_data.tile_word, rsp_data.status, rsp_data.last_of_run);
               errors++;
            end else begin
               want = tile_q.pop_front();
               checked_cnt++;
               if (rsp_data.tile_word !== want.tile_word) begin
                  $error("tile_word: expected %h, actual %h", want.tile_word, rsp_data.tile_word);
                  errors++;
               end
               if (rsp_data.status !== want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, rsp_data.status);
                  errors++;
               end
               if (rsp_data.last_of_run !== want.last_of_run) begin
                  $error("last_of_run: expected %0d, actual %0d",
                         want.last_of_run, rsp_data.last_of_run);
                  errors++;
               end
            end
         end
      end
   end

   // main sequence
   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      set_base_tile(16'h0000);

      // byte before any start is ignored
      queue_byte(8'hA5, 1'b0);
      // bad width at both ends of the byte range
      queue_byte(8'h00, 1'b1);
      queue_byte(8'hFF, 1'b1);

      // widest inline values with every flag bit
      send_header(8'd16, 8'hFF, 16'hFFFF, 16'h0000);
      put_bits(PKT_REPEAT, 3);
      put_bits(0, 4);
      put_inline(5'h1F, 16'hFFFF, 16, 5'h1F);
      put_bits(PKT_DOWN, 3);
      put_bits(1, 4);
      put_inline(5'h00, 16'h0000, 16, 5'h1F);
      put_bits(END_MARK, 7);
      pack_stream();

      // narrowest values; the fourth bitstream byte yields a full output run
      send_header(8'd1, 8'h00, 16'h1234, 16'hABCD);
      put_packet(PKT_INC, 4'd0, 1, 5'h00);
      put_packet(PKT_COMMON, 4'd0, 1, 5'h00);
      put_packet(PKT_INC, 4'd0, 1, 5'h00);
      put_bits(PKT_REPEAT, 3);
      put_bits(15, 4);
      put_inline(5'h00, 1, 1, 5'h00);
      put_packet(PKT_INC, 4'd15, 1, 5'h00);
      put_packet(PKT_UP, 4'd1, 1, 5'h00);
      put_packet(PKT_DOWN, 4'd1, 1, 5'h00);
      put_packet(PKT_LIST, 4'd1, 1, 5'h00);
      put_bits(END_MARK, 7);
      pack_stream();
      // trailing byte after the end marker
      queue_byte(8'h5A, 1'b0);

      // random phases under several base_tile settings
      wait_drained();
      set_base_tile(16'hFFFF);
      random_traffic(PHASE_ITEMS);
      wait_drained();
      set_base_tile(16'($urandom));
      random_traffic(PHASE_ITEMS);
      wait_drained();
      set_base_tile(16'h0001);
      random_traffic(PHASE_ITEMS);
      wait_drained();
      set_base_tile(16'h0000);
      random_traffic(PHASE_ITEMS);
      wait_drained();
      set_base_tile(16'($urandom));
      random_traffic(PHASE_ITEMS);
      wait_drained();

      $display("run covered %0d input transactions over %0d streams, %0d base_tile writes",
               accepted_cnt, streams_built, base_writes);
      $display("%0d result transactions compared, %0d mismatches", checked_cnt, errors);
      if (errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // watchdog
   initial begin
      #4000000;
      $display("timeout: %0d results still owed", tile_q.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
